// ----- rtl/tfn_pkg.sv -----
// tfn_pkg: widths and pipeline payload types for the triangle flat normal unit
// no dependencies
package tfn_pkg;

    localparam int COORD_W   = 16;
    localparam int EDGE_W    = COORD_W + 1;
    localparam int PROD_W    = 2 * EDGE_W;
    localparam int CMAG_W    = PROD_W - 1;
    localparam int SQ_W      = 2 * CMAG_W;
    localparam int SUM_W     = SQ_W + 2;
    localparam int FRAC_W    = 14;
    localparam int ROOT_W    = FRAC_W + 2;
    localparam int STEP_W    = $clog2(ROOT_W) + 1;
    localparam int RES_W     = SUM_W + 2 * ROOT_W;
    localparam int QUOT_W    = FRAC_W + 1;
    localparam int NORMAL_W  = 16;

    typedef struct packed {
        logic [2:0][CMAG_W-1:0] mag;
        logic [2:0]             neg;
    } cross_t;

    typedef struct packed {
        logic [SUM_W-1:0]       sum;
        logic [2:0][RES_W-1:0]  res;
        logic [2:0][RES_W-1:0]  part;
        logic [2:0][ROOT_W-1:0] root;
        logic [2:0]             neg;
        logic                   zero;
    } root_t;

endpackage

// ----- rtl/tfn_cross.sv -----
// tfn_cross: edge vectors, cross product terms and component magnitudes
// three register stages; depends on tfn_pkg
module tfn_cross (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               en,
    input  logic                               in_valid,
    input  logic signed [tfn_pkg::COORD_W-1:0] first [3],
    input  logic signed [tfn_pkg::COORD_W-1:0] second [3],
    input  logic signed [tfn_pkg::COORD_W-1:0] third [3],
    output logic                               out_valid,
    output tfn_pkg::cross_t                    out
);
    import tfn_pkg::*;

    logic signed [EDGE_W-1:0] ea_reg [3];
    logic signed [EDGE_W-1:0] eb_reg [3];
    logic signed [PROD_W-1:0] pp_reg [3];
    logic signed [PROD_W-1:0] pq_reg [3];
    logic signed [PROD_W:0]   diff [3];
    logic [2:0]               valid_reg;
    cross_t                   out_reg;
    cross_t                   out_next;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            diff[i] = {pp_reg[i][PROD_W-1], pp_reg[i]} - {pq_reg[i][PROD_W-1], pq_reg[i]};
            out_next.neg[i] = diff[i][PROD_W];
            out_next.mag[i] = diff[i][PROD_W] ? CMAG_W'(-diff[i]) : CMAG_W'(diff[i]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (en) begin
            valid_reg <= {valid_reg[1:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                ea_reg[i] <= $signed({second[i][COORD_W-1], second[i]})
                           - $signed({first[i][COORD_W-1], first[i]});
                eb_reg[i] <= $signed({third[i][COORD_W-1], third[i]})
                           - $signed({first[i][COORD_W-1], first[i]});
            end
            pp_reg[0] <= ea_reg[1] * eb_reg[2];
            pq_reg[0] <= ea_reg[2] * eb_reg[1];
            pp_reg[1] <= ea_reg[2] * eb_reg[0];
            pq_reg[1] <= ea_reg[0] * eb_reg[2];
            pp_reg[2] <= ea_reg[0] * eb_reg[1];
            pq_reg[2] <= ea_reg[1] * eb_reg[0];
            out_reg   <= out_next;
        end
    end

    assign out_valid = valid_reg[2];
    assign out       = out_reg;

endmodule

// ----- rtl/tfn_norm_sq.sv -----
// tfn_norm_sq: squares of the cross components and their sum, root stage setup
// two register stages; depends on tfn_pkg
module tfn_norm_sq (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            en,
    input  logic            in_valid,
    input  tfn_pkg::cross_t in,
    output logic            out_valid,
    output tfn_pkg::root_t  out
);
    import tfn_pkg::*;

    logic [2:0][SQ_W-1:0] sq_reg;
    logic [2:0]           neg_reg;
    logic [1:0]           valid_reg;
    root_t                out_reg;
    root_t                out_next;

    always_comb begin
        out_next.sum = SUM_W'(sq_reg[0]) + SUM_W'(sq_reg[1]) + SUM_W'(sq_reg[2]);
        out_next.zero = (out_next.sum == '0);
        out_next.neg  = neg_reg;
        for (int i = 0; i < 3; i++) begin
            // target c^2 * 2^(2*(frac+1))
            out_next.res[i]  = RES_W'(sq_reg[i]) << (2 * (FRAC_W + 1));
            out_next.part[i] = '0;
            out_next.root[i] = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (en) begin
            valid_reg <= {valid_reg[0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                sq_reg[i] <= in.mag[i] * in.mag[i];
            end
            neg_reg <= in.neg;
            out_reg <= out_next;
        end
    end

    assign out_valid = valid_reg[1];
    assign out       = out_reg;

endmodule

// ----- rtl/tfn_root_step.sv -----
// tfn_root_step: one bit of the scaled quotient root for all three components
// one register stage; depends on tfn_pkg
module tfn_root_step (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       en,
    input  logic [tfn_pkg::STEP_W-1:0] step,
    input  logic                       in_valid,
    input  tfn_pkg::root_t             in,
    output logic                       out_valid,
    output tfn_pkg::root_t             out
);
    import tfn_pkg::*;

    logic [RES_W-1:0] sum_ext;
    logic [RES_W-1:0] cand [3];
    logic [RES_W:0]   diff [3];
    logic             take [3];
    logic             valid_reg;
    root_t            out_reg;
    root_t            out_next;

    always_comb begin
        sum_ext  = RES_W'(in.sum);
        out_next = in;
        for (int i = 0; i < 3; i++) begin
            // (m + 2^b)^2 S - m^2 S = 2^(b+1) m S + 2^(2b) S
            cand[i] = (in.part[i] << (step + STEP_W'(1))) + (sum_ext << (step << 1));
            diff[i] = {1'b0, in.res[i]} - {1'b0, cand[i]};
            take[i] = !diff[i][RES_W];
            if (take[i]) begin
                out_next.res[i]  = diff[i][RES_W-1:0];
                out_next.part[i] = in.part[i] + (sum_ext << step);
                out_next.root[i] = in.root[i] | (ROOT_W'(1) << step);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            out_reg <= out_next;
        end
    end

    assign out_valid = valid_reg;
    assign out       = out_reg;

endmodule

// ----- rtl/triangle_flat_normal.sv -----
// triangle_flat_normal: unit face normal of a triangle, Q8.8 in, Q1.14 out
// the pipeline has 3 cross product stages, 2 sum of squares stages,
// 16 root stages (one quotient bit each) and the output register
// throughput one triangle per cycle; a stall on m_ready holds every stage
// reset (aresetn low, synchronous) clears all valid bits; payload is not reset
// depends on tfn_pkg, tfn_cross, tfn_norm_sq, tfn_root_step
module triangle_flat_normal (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic signed [tfn_pkg::COORD_W-1:0]  s_first_x,
    input  logic signed [tfn_pkg::COORD_W-1:0]  s_first_y,
    input  logic signed [tfn_pkg::COORD_W-1:0]  s_first_z,
    input  logic signed [tfn_pkg::COORD_W-1:0]  s_second_x,
    input  logic signed [tfn_pkg::COORD_W-1:0]  s_second_y,
    input  logic signed [tfn_pkg::COORD_W-1:0]  s_second_z,
    input  logic signed [tfn_pkg::COORD_W-1:0]  s_third_x,
    input  logic signed [tfn_pkg::COORD_W-1:0]  s_third_y,
    input  logic signed [tfn_pkg::COORD_W-1:0]  s_third_z,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic signed [tfn_pkg::NORMAL_W-1:0] m_normal_x,
    output logic signed [tfn_pkg::NORMAL_W-1:0] m_normal_y,
    output logic signed [tfn_pkg::NORMAL_W-1:0] m_normal_z,
    output logic                                m_degenerate
);
    import tfn_pkg::*;

    logic                       en;
    logic signed [COORD_W-1:0]  first [3];
    logic signed [COORD_W-1:0]  second [3];
    logic signed [COORD_W-1:0]  third [3];
    logic                       cross_valid;
    cross_t                     cross_data;
    logic                       root_valid [ROOT_W+1];
    root_t                      root_data [ROOT_W+1];
    root_t                      fin;
    logic [ROOT_W:0]            round_sum [3];
    logic [QUOT_W-1:0]          quot [3];
    logic signed [NORMAL_W-1:0] norm_next [3];
    logic signed [NORMAL_W-1:0] norm_reg [3];
    logic                       degen_reg;
    logic                       valid_reg;

    assign en      = !valid_reg || m_ready;
    assign s_ready = en;

    assign first  = '{s_first_x, s_first_y, s_first_z};
    assign second = '{s_second_x, s_second_y, s_second_z};
    assign third  = '{s_third_x, s_third_y, s_third_z};

    tfn_cross u_cross (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (s_valid),
        .first     (first),
        .second    (second),
        .third     (third),
        .out_valid (cross_valid),
        .out       (cross_data)
    );

    tfn_norm_sq u_norm_sq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (cross_valid),
        .in        (cross_data),
        .out_valid (root_valid[0]),
        .out       (root_data[0])
    );

    for (genvar g = 0; g < ROOT_W; g++) begin : g_root
        tfn_root_step u_step (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (en),
            .step      (STEP_W'(ROOT_W - 1 - g)),
            .in_valid  (root_valid[g]),
            .in        (root_data[g]),
            .out_valid (root_valid[g+1]),
            .out       (root_data[g+1])
        );
    end

    assign fin = root_data[ROOT_W];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            // largest q with 2q-1 <= m
            round_sum[i] = {1'b0, fin.root[i]} + (ROOT_W+1)'(1);
            quot[i]      = round_sum[i][QUOT_W:1];
            if (fin.zero) begin
                norm_next[i] = '0;
            end else if (fin.neg[i]) begin
                norm_next[i] = -$signed(NORMAL_W'(quot[i]));
            end else begin
                norm_next[i] = $signed(NORMAL_W'(quot[i]));
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= root_valid[ROOT_W];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            norm_reg  <= norm_next;
            degen_reg <= fin.zero;
        end
    end

    assign m_valid      = valid_reg;
    assign m_normal_x   = norm_reg[0];
    assign m_normal_y   = norm_reg[1];
    assign m_normal_z   = norm_reg[2];
    assign m_degenerate = degen_reg;

`ifndef SYNTHESIS
    localparam logic signed [NORMAL_W-1:0] UNIT = NORMAL_W'(1) << FRAC_W;

    a_degen_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_degenerate |-> m_normal_x == '0 && m_normal_y == '0 && m_normal_z == '0)
        else $error("degenerate beat with nonzero normal");

    a_unit_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_normal_x <= UNIT && m_normal_x >= -UNIT
                 && m_normal_y <= UNIT && m_normal_y >= -UNIT
                 && m_normal_z <= UNIT && m_normal_z >= -UNIT)
        else $error("normal component beyond unit length");

    a_not_all_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_degenerate |-> m_normal_x != '0 || m_normal_y != '0 || m_normal_z != '0)
        else $error("nondegenerate beat with zero normal");

    a_reset_clear: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("output beat valid right after reset");
`endif

endmodule

// ----- tb/sv/triangle_flat_normal_tb.sv -----
`timescale 1ns / 1ps
// triangle_flat_normal_tb: random and directed check of the face normal unit
// predicts each unit normal with exact wide integer math and compares every result beat
// depends on tfn_pkg and triangle_flat_normal
module triangle_flat_normal_tb;
    import tfn_pkg::*;

    typedef struct packed {
        logic [8:0][COORD_W-1:0] c;
    } tri_t;

    typedef struct packed {
        logic [NORMAL_W-1:0] x;
        logic [NORMAL_W-1:0] y;
        logic [NORMAL_W-1:0] z;
        logic                degen;
    } normal_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic signed [COORD_W-1:0] s_c [9] = '{default: '0};
    logic m_valid;
    logic m_ready = 1'b0;
    logic signed [NORMAL_W-1:0] m_normal_x, m_normal_y, m_normal_z;
    logic m_degenerate;

    tri_t    pending_tris[$];
    normal_t expected_normals[$];
    tri_t    offered;
    bit      beat_taken = 1'b0;
    bit      rx_hold = 1'b0;
    int      idle_pct = 0;
    int      stall_pct = 0;
    int      errors = 0;
    int      results_seen = 0;
    int      degen_seen = 0;

    triangle_flat_normal u_top (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_first_x   (s_c[0]),
        .s_first_y   (s_c[1]),
        .s_first_z   (s_c[2]),
        .s_second_x  (s_c[3]),
        .s_second_y  (s_c[4]),
        .s_second_z  (s_c[5]),
        .s_third_x   (s_c[6]),
        .s_third_y   (s_c[7]),
        .s_third_z   (s_c[8]),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_normal_x  (m_normal_x),
        .m_normal_y  (m_normal_y),
        .m_normal_z  (m_normal_z),
        .m_degenerate(m_degenerate)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // exact rounded quotient c * 2^14 / sqrt(s), ties away from zero
    function automatic logic [31:0] rounded_ratio(logic [159:0] c, logic [159:0] s);
        logic [159:0] rhs, od;
        logic [31:0] lo, hi, mid;
        rhs = (c << (FRAC_W + 1)) * (c << (FRAC_W + 1));
        lo = 0;
        hi = 32'd1 << FRAC_W;
        while (lo < hi) begin
            mid = lo + (hi - lo + 1) / 2;
            od = 160'(2 * mid - 1);
            if (od * od * s <= rhs) lo = mid;
            else hi = mid - 1;
        end
        return lo;
    endfunction

    function automatic normal_t face_normal(tri_t t);
        logic signed [63:0] f[3], a[3], b[3], cr[3];
        logic [159:0] mag[3], s;
        logic [31:0] q[3];
        normal_t r;
        s = '0;
        for (int i = 0; i < 3; i++) begin
            f[i] = $signed(t.c[i]);
            a[i] = 64'($signed(t.c[3 + i])) - f[i];
            b[i] = 64'($signed(t.c[6 + i])) - f[i];
        end
        for (int i = 0; i < 3; i++) begin
            cr[i] = a[(i + 1) % 3] * b[(i + 2) % 3] - a[(i + 2) % 3] * b[(i + 1) % 3];
            mag[i] = '0;
            mag[i][63:0] = cr[i] < 0 ? -cr[i] : cr[i];
            s = s + mag[i] * mag[i];
        end
        if (s == 0) begin
            r = '0;
            r.degen = 1'b1;
            return r;
        end
        for (int i = 0; i < 3; i++) begin
            q[i] = rounded_ratio(mag[i], s);
            if (cr[i] < 0) q[i] = -q[i];
        end
        r.x = q[0][NORMAL_W-1:0];
        r.y = q[1][NORMAL_W-1:0];
        r.z = q[2][NORMAL_W-1:0];
        r.degen = 1'b0;
        return r;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        errors++;
        $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
    endtask

    // driver
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || beat_taken) begin
            beat_taken = 1'b0;
            if (pending_tris.size() > 0 && $urandom_range(99) >= idle_pct) begin
                offered = pending_tris.pop_front();
                for (int i = 0; i < 9; i++) s_c[i] <= offered.c[i];
                s_valid <= 1'b1;
            end else begin
                s_valid <= 1'b0;
            end
        end
        m_ready <= aresetn && !rx_hold && ($urandom_range(99) >= stall_pct);
    end

    // monitor
    always @(posedge aclk) begin
        normal_t want;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                expected_normals.insert(expected_normals.size(), face_normal(offered));
                beat_taken = 1'b1;
            end
            if (m_valid && m_ready) begin
                results_seen++;
                if (m_degenerate) degen_seen++;
                if (expected_normals.size() == 0) begin
                    errors++;
                    $display("unexpected result beat at %0t", $realtime);
                end else begin
                    want = expected_normals.pop_front();
                    if (m_normal_x !== want.x)
                        report_mismatch("normal_x", m_normal_x, $signed(want.x));
                    if (m_normal_y !== want.y)
                        report_mismatch("normal_y", m_normal_y, $signed(want.y));
                    if (m_normal_z !== want.z)
                        report_mismatch("normal_z", m_normal_z, $signed(want.z));
                    if (m_degenerate !== want.degen)
                        report_mismatch("degenerate", m_degenerate, want.degen);
                end
            end
        end
    end

    function automatic tri_t make_tri(int v[9]);
        tri_t t;
        for (int i = 0; i < 9; i++) t.c[i] = v[i][COORD_W-1:0];
        return t;
    endfunction

    function automatic tri_t random_tri();
        tri_t t;
        int sel, k;
        logic [COORD_W-1:0] d[3];
        sel = $urandom_range(9);
        for (int i = 0; i < 9; i++) t.c[i] = $urandom();
        if (sel < 3) begin
            // small triangle near a random origin
            for (int i = 3; i < 9; i++)
                t.c[i] = t.c[i % 3] + COORD_W'($urandom_range(64) - 32);
        end else if (sel == 3) begin
            // collinear or coincident vertices
            k = $urandom_range(3) - 1;
            for (int i = 0; i < 3; i++) begin
                d[i] = COORD_W'($urandom_range(200) - 100);
                t.c[3 + i] = t.c[i] + d[i];
                t.c[6 + i] = t.c[i] + COORD_W'(k) * d[i];
            end
        end else if (sel == 4) begin
            // axis aligned edges
            for (int i = 3; i < 9; i++) t.c[i] = t.c[i % 3];
            t.c[3 + $urandom_range(2)] = $urandom();
            t.c[6 + $urandom_range(2)] = $urandom();
        end
        return t;
    endfunction

    task automatic queue_tri(tri_t t);
        pending_tris.insert(pending_tris.size(), t);
    endtask

    task automatic wait_drained();
        while (pending_tris.size() > 0 || s_valid || expected_normals.size() > 0)
            @(posedge aclk);
    endtask

    initial begin
        int lo, hi;
        lo = -32768;
        hi = 32767;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        queue_tri(make_tri('{0, 0, 0, 0, 0, 0, 0, 0, 0}));
        queue_tri(make_tri('{0, 0, 0, 256, 0, 0, 0, 256, 0}));
        queue_tri(make_tri('{0, 0, 0, 0, 256, 0, 256, 0, 0}));
        queue_tri(make_tri('{0, 0, 0, 0, 1, 0, 0, 0, 1}));
        queue_tri(make_tri('{0, 0, 0, 0, 0, 1, 1, 0, 0}));
        queue_tri(make_tri('{lo, lo, lo, hi, lo, lo, lo, hi, lo}));
        queue_tri(make_tri('{hi, hi, hi, lo, hi, hi, hi, lo, hi}));
        queue_tri(make_tri('{lo, lo, lo, hi, hi, hi, lo, hi, lo}));
        queue_tri(make_tri('{hi, lo, hi, lo, hi, lo, lo, lo, hi}));
        queue_tri(make_tri('{lo, lo, lo, lo, lo, lo, lo, lo, lo}));
        queue_tri(make_tri('{hi, hi, hi, hi, hi, hi, hi, hi, hi}));
        queue_tri(make_tri('{0, 0, 0, 1, 1, 1, 2, 2, 2}));
        queue_tri(make_tri('{lo, lo, lo, 0, 0, 0, hi, hi, hi}));
        queue_tri(make_tri('{0, 0, 0, 1, 0, 0, 0, 1, 1}));
        queue_tri(make_tri('{0, 0, 0, 3, 0, 0, 0, 4, 0}));
        queue_tri(make_tri('{-1, -1, -1, 0, -1, -1, -1, 0, -1}));
        queue_tri(make_tri('{5, -7, 9, 5, -7, 9, 100, 3, -40}));

        // long receiver hold-off while the sender keeps offering
        idle_pct = 0;
        stall_pct = 0;
        for (int i = 0; i < 400; i++) queue_tri(random_tri());
        rx_hold = 1'b1;
        repeat (300) @(posedge aclk);
        rx_hold = 1'b0;
        wait_drained();

        for (int ph = 0; ph < 4; ph++) begin
            idle_pct  = (ph == 0) ? 0 : (ph == 1) ? 82 : (ph == 2) ? 0 : 35;
            stall_pct = (ph == 0) ? 0 : (ph == 1) ? 0 : (ph == 2) ? 82 : 35;
            for (int i = 0; i < 400; i++) queue_tri(random_tri());
            wait_drained();
        end
        repeat (40) @(posedge aclk);

        $display("covered %0d triangles, %0d degenerate, over five idle and stall mixes",
                 results_seen, degen_seen);
        if (errors == 0 && expected_normals.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    initial begin
        #5_000_000;
        $display("timeout with %0d results outstanding", expected_normals.size());
        $display("DONE: errors detected");
        $finish;
    end
endmodule

// ----- files.f -----
rtl/tfn_pkg.sv
rtl/tfn_cross.sv
rtl/tfn_norm_sq.sv
rtl/tfn_root_step.sv
rtl/triangle_flat_normal.sv
tb/sv/triangle_flat_normal_tb.sv
